// ===== hw/rtl/csaf_pkg.sv =====
`timescale 1ns / 1ps

package csaf_pkg;

    // Field widths.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MAC_W   = 48;
    localparam int unsigned RSSI_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned RATE_W  = 10;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    // Low part of the elapsed time that takes part in the rate check.
    // The longest period is 1000 ms, so anything at or above 1024 ms passes.
    localparam int unsigned DELTA_LO_W = 10;
    localparam int unsigned PROD_W     = DELTA_LO_W + 1 + RATE_W;

    localparam logic [LEN_W-1:0]  MAX_SAMPLE_BYTES = 16'd384;
    localparam logic [PROD_W-1:0] MS_PER_SECOND    = PROD_W'(1000);
    localparam logic signed [RSSI_W-1:0] MIN_SIGNAL_RESET = -8'sd127;

    typedef enum logic [2:0] {
        V_ACCEPTED = 3'd0,
        V_IDLE     = 3'd1,
        V_BADLEN   = 3'd2,
        V_MAC      = 3'd3,
        V_WEAK     = 3'd4,
        V_RATE     = 3'd5,
        V_DROPPED  = 3'd6
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_RUN     = 3'd0,
        CFG_MAC_FILTER_ON  = 3'd1,
        CFG_FILTER_ADDRESS = 3'd2,
        CFG_MIN_SIGNAL     = 3'd3,
        CFG_LIMIT_HZ       = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EVAL = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input word and its pre-checks
        logic commit;  // decide, update counters, load the output register
    } t_cmd;

endpackage

// ===== hw/rtl/csaf_ctrl.sv =====
`timescale 1ns / 1ps

module csaf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output csaf_pkg::t_cmd  o_cmd
);

    csaf_pkg::t_state r_state;
    csaf_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csaf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != csaf_pkg::S_IDLE);
        case (r_state)
            csaf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = csaf_pkg::S_EVAL;
                end
            end
            csaf_pkg::S_EVAL: begin
                // The result may only be written once the output register is free
                // or is being taken in this cycle.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = csaf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csaf_pkg::S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit | (r_out_valid & i_out_stall);
    end

    assign o_out_valid = r_out_valid;

    a_load_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == csaf_pkg::S_EVAL))
        else $error("accepted word did not move the controller to evaluation");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("committed result is not presented");

    a_wait_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csaf_pkg::S_EVAL && r_out_valid && i_out_stall)
        |=> (r_state == csaf_pkg::S_EVAL))
        else $error("evaluation left while the output register was occupied");

endmodule

// ===== hw/rtl/csaf_datapath.sv =====
`timescale 1ns / 1ps

module csaf_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  csaf_pkg::t_cmd                        i_cmd,
    input  logic                                  i_cfg_we,
    input  logic [csaf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csaf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [csaf_pkg::TIME_W-1:0]           i_now_ms,
    input  logic [csaf_pkg::MAC_W-1:0]            i_src_mac,
    input  logic signed [csaf_pkg::RSSI_W-1:0]    i_rssi,
    input  logic [csaf_pkg::LEN_W-1:0]            i_csi_len,
    input  logic                                  i_queue_full,
    output logic [2:0]                            o_verdict,
    output logic [csaf_pkg::COUNT_W-1:0]          o_accepted_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_bad_length_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_weak_signal_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_rate_limited_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_dropped_total
);

    // Configuration.
    logic                                r_enable_run;
    logic                                r_mac_filter_on;
    logic [csaf_pkg::MAC_W-1:0]          r_filter_address;
    logic signed [csaf_pkg::RSSI_W-1:0]  r_min_signal;
    logic [csaf_pkg::RATE_W-1:0]         r_limit_hz;

    // Filter state.
    logic [csaf_pkg::TIME_W-1:0]  r_last_pass_ms, n_last_pass_ms;
    logic [csaf_pkg::COUNT_W-1:0] r_accepted_count, n_accepted_count;
    logic [csaf_pkg::COUNT_W-1:0] r_bad_length_count, n_bad_length_count;
    logic [csaf_pkg::COUNT_W-1:0] r_weak_signal_count, n_weak_signal_count;
    logic [csaf_pkg::COUNT_W-1:0] r_rate_limited_count, n_rate_limited_count;
    logic [csaf_pkg::COUNT_W-1:0] r_dropped_count, n_dropped_count;

    // Captured word and its pre-checks.
    logic [csaf_pkg::TIME_W-1:0]     r_now_ms;
    logic                            r_queue_full;
    logic                            r_len_bad;
    logic                            r_mac_bad;
    logic                            r_weak;
    logic                            r_near;
    logic [csaf_pkg::DELTA_LO_W-1:0] r_delta_lo;
    logic [csaf_pkg::TIME_W-1:0]     n_delta;

    // Output register.
    csaf_pkg::t_verdict              r_verdict;
    csaf_pkg::t_verdict              n_verdict;
    logic [csaf_pkg::COUNT_W-1:0]    r_out_accepted, r_out_bad_length, r_out_weak_signal;
    logic [csaf_pkg::COUNT_W-1:0]    r_out_rate_limited, r_out_dropped;

    logic [csaf_pkg::DELTA_LO_W:0]   w_step;
    logic [csaf_pkg::PROD_W-1:0]     w_prod;
    logic                            w_rate_hit;

    assign n_delta = i_now_ms - r_last_pass_ms;

    // delta < 1000 / hz  is the same as  (delta + 1) * hz <= 1000.
    assign w_step     = {1'b0, r_delta_lo} + {{csaf_pkg::DELTA_LO_W{1'b0}}, 1'b1};
    assign w_prod     = {{csaf_pkg::RATE_W{1'b0}}, w_step}
                      * {{(csaf_pkg::DELTA_LO_W + 1){1'b0}}, r_limit_hz};
    assign w_rate_hit = (r_limit_hz != '0) && r_near && (w_prod <= csaf_pkg::MS_PER_SECOND);

    always_comb begin
        n_verdict            = csaf_pkg::V_ACCEPTED;
        n_last_pass_ms       = r_last_pass_ms;
        n_accepted_count     = r_accepted_count;
        n_bad_length_count   = r_bad_length_count;
        n_weak_signal_count  = r_weak_signal_count;
        n_rate_limited_count = r_rate_limited_count;
        n_dropped_count      = r_dropped_count;
        if (!r_enable_run) begin
            n_verdict = csaf_pkg::V_IDLE;
        end else if (r_len_bad) begin
            n_verdict          = csaf_pkg::V_BADLEN;
            n_bad_length_count = r_bad_length_count + 1'b1;
        end else if (r_mac_bad) begin
            n_verdict = csaf_pkg::V_MAC;
        end else if (r_weak) begin
            n_verdict           = csaf_pkg::V_WEAK;
            n_weak_signal_count = r_weak_signal_count + 1'b1;
        end else if (w_rate_hit) begin
            n_verdict            = csaf_pkg::V_RATE;
            n_rate_limited_count = r_rate_limited_count + 1'b1;
        end else begin
            // A sample that clears the rate check restarts the period even
            // when it is then lost to a full queue.
            if (r_limit_hz != '0) begin
                n_last_pass_ms = r_now_ms;
            end
            if (r_queue_full) begin
                n_verdict       = csaf_pkg::V_DROPPED;
                n_dropped_count = r_dropped_count + 1'b1;
            end else begin
                n_accepted_count = r_accepted_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_run         <= 1'b0;
            r_mac_filter_on      <= 1'b0;
            r_filter_address     <= '0;
            r_min_signal         <= csaf_pkg::MIN_SIGNAL_RESET;
            r_limit_hz           <= '0;
            r_last_pass_ms       <= '0;
            r_accepted_count     <= '0;
            r_bad_length_count   <= '0;
            r_weak_signal_count  <= '0;
            r_rate_limited_count <= '0;
            r_dropped_count      <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_last_pass_ms       <= n_last_pass_ms;
                r_accepted_count     <= n_accepted_count;
                r_bad_length_count   <= n_bad_length_count;
                r_weak_signal_count  <= n_weak_signal_count;
                r_rate_limited_count <= n_rate_limited_count;
                r_dropped_count      <= n_dropped_count;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    csaf_pkg::CFG_ENABLE_RUN:     r_enable_run     <= i_cfg_data[0];
                    csaf_pkg::CFG_MAC_FILTER_ON:  r_mac_filter_on  <= i_cfg_data[0];
                    csaf_pkg::CFG_FILTER_ADDRESS: r_filter_address <= i_cfg_data;
                    csaf_pkg::CFG_MIN_SIGNAL: begin
                        r_min_signal <= i_cfg_data[csaf_pkg::RSSI_W-1:0];
                    end
                    csaf_pkg::CFG_LIMIT_HZ: begin
                        r_limit_hz     <= i_cfg_data[csaf_pkg::RATE_W-1:0];
                        r_last_pass_ms <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now_ms     <= i_now_ms;
            r_queue_full <= i_queue_full;
            r_len_bad    <= (i_csi_len == '0) || (i_csi_len > csaf_pkg::MAX_SAMPLE_BYTES);
            r_mac_bad    <= r_mac_filter_on && (i_src_mac != r_filter_address);
            r_weak       <= (i_rssi < r_min_signal);
            r_near       <= (n_delta[csaf_pkg::TIME_W-1:csaf_pkg::DELTA_LO_W] == '0);
            r_delta_lo   <= n_delta[csaf_pkg::DELTA_LO_W-1:0];
        end
        if (i_cmd.commit) begin
            r_verdict          <= n_verdict;
            r_out_accepted     <= n_accepted_count;
            r_out_bad_length   <= n_bad_length_count;
            r_out_weak_signal  <= n_weak_signal_count;
            r_out_rate_limited <= n_rate_limited_count;
            r_out_dropped      <= n_dropped_count;
        end
    end

    assign o_verdict            = r_verdict;
    assign o_accepted_total     = r_out_accepted;
    assign o_bad_length_total   = r_out_bad_length;
    assign o_weak_signal_total  = r_out_weak_signal;
    assign o_rate_limited_total = r_out_rate_limited;
    assign o_dropped_total      = r_out_dropped;

    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_verdict == csaf_pkg::V_IDLE)
        |=> $stable({r_accepted_count, r_bad_length_count, r_weak_signal_count,
                     r_rate_limited_count, r_dropped_count}))
        else $error("an ignored sample changed a counter");

    a_rate_needs_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_verdict == csaf_pkg::V_RATE) |-> (r_limit_hz != '0))
        else $error("rate limited verdict with limiting disabled");

    a_accept_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_verdict == csaf_pkg::V_ACCEPTED)
        |=> (r_accepted_count == $past(r_accepted_count) + 1'b1))
        else $error("accepted sample not counted");

endmodule

// ===== hw/rtl/csi_sample_admission_filter_top.sv =====
`timescale 1ns / 1ps

// Admission filter for channel-state sample descriptors. Each word taken on
// the input channel yields exactly one result word: a verdict (accepted,
// idle, bad length, MAC mismatch, weak signal, rate limited, dropped) and a
// snapshot of the five wrapping 32-bit counters after that sample. A word
// is first captured with its length, address, signal and elapsed-time
// checks, then decided: the counters are updated and the output register
// loaded. The input stalls until that word is committed, so a new word is
// taken only after the previous one is through. The single output
// register sets the limit when the consumer stalls: evaluation waits until
// it is free. The rate check compares (elapsed + 1) * limit_hz against 1000
// with one small multiplier, which equals testing the elapsed time against
// 1000 / limit_hz. Configuration writes are taken in any cycle but must
// only be issued while no sample is in flight; writing limit_hz also clears
// the last-pass time.

module csi_sample_admission_filter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [csaf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [csaf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input channel.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [csaf_pkg::TIME_W-1:0]           i_now_ms,
    input  logic [csaf_pkg::MAC_W-1:0]            i_src_mac,
    input  logic signed [csaf_pkg::RSSI_W-1:0]    i_rssi,
    input  logic [csaf_pkg::LEN_W-1:0]            i_csi_len,
    input  logic                                  i_queue_full,
    // Output channel.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [2:0]                            o_verdict,
    output logic [csaf_pkg::COUNT_W-1:0]          o_accepted_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_bad_length_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_weak_signal_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_rate_limited_total,
    output logic [csaf_pkg::COUNT_W-1:0]          o_dropped_total
);

    // Commands from the controller: load captures a word, commit decides it.
    csaf_pkg::t_cmd w_cmd;

    csaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the configuration, counters, the captured word and
    // the output payload register.
    csaf_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_now_ms             (i_now_ms),
        .i_src_mac            (i_src_mac),
        .i_rssi               (i_rssi),
        .i_csi_len            (i_csi_len),
        .i_queue_full         (i_queue_full),
        .o_verdict            (o_verdict),
        .o_accepted_total     (o_accepted_total),
        .o_bad_length_total   (o_bad_length_total),
        .o_weak_signal_total  (o_weak_signal_total),
        .o_rate_limited_total (o_rate_limited_total),
        .o_dropped_total      (o_dropped_total)
    );

endmodule

// ===== dv/tb_csi_sample_admission_filter_top.sv =====
`timescale 1ns / 1ps

module tb_csi_sample_admission_filter_top;

    // The admission filter is driven one sample word at a time. A small
    // scoreboard class mirrors the filter: it keeps its own copy of the five
    // registers, the last-pass time and the five counters. Each accepted word
    // queues one expected verdict with its counter snapshot. Each result word
    // taken from the block is compared field by field with the oldest entry.

    localparam int unsigned TIME_W     = csaf_pkg::TIME_W;
    localparam int unsigned MAC_W      = csaf_pkg::MAC_W;
    localparam int unsigned RSSI_W     = csaf_pkg::RSSI_W;
    localparam int unsigned LEN_W      = csaf_pkg::LEN_W;
    localparam int unsigned RATE_W     = csaf_pkg::RATE_W;
    localparam int unsigned COUNT_W    = csaf_pkg::COUNT_W;
    localparam int unsigned CFG_IDX_W  = csaf_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = csaf_pkg::CFG_DATA_W;

    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned IDLE_PCT     = 33;
    localparam int unsigned RANDOM_WORDS = 750;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        logic [TIME_W-1:0]        now_ms;
        logic [MAC_W-1:0]         src_mac;
        logic signed [RSSI_W-1:0] rssi;
        logic [LEN_W-1:0]         csi_len;
        logic                     queue_full;
    } t_sample;

    // One result word: the verdict and the counters after that sample.
    typedef struct {
        csaf_pkg::t_verdict verdict;
        logic [COUNT_W-1:0] accepted;
        logic [COUNT_W-1:0] bad_length;
        logic [COUNT_W-1:0] weak_signal;
        logic [COUNT_W-1:0] rate_limited;
        logic [COUNT_W-1:0] dropped;
    } t_tally;

    class admission_scoreboard;
        logic                     run_en;
        logic                     mac_filter;
        logic [MAC_W-1:0]         match_addr;
        logic signed [RSSI_W-1:0] min_rssi;
        logic [RATE_W-1:0]        rate_hz;
        logic [TIME_W-1:0]        last_pass_ms;
        t_tally                   totals;
        t_tally                   due_verdicts[$];
        int unsigned              mismatches;

        function new();
            run_en              = 1'b0;
            mac_filter          = 1'b0;
            match_addr          = '0;
            min_rssi            = csaf_pkg::MIN_SIGNAL_RESET;
            rate_hz             = '0;
            last_pass_ms        = '0;
            totals.verdict      = csaf_pkg::V_ACCEPTED;
            totals.accepted     = '0;
            totals.bad_length   = '0;
            totals.weak_signal  = '0;
            totals.rate_limited = '0;
            totals.dropped      = '0;
            mismatches          = 0;
        endfunction

        // Only the low bits of the data word belong to each register.
        // Writing the rate also restarts the last-pass time from zero.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                csaf_pkg::CFG_ENABLE_RUN:     run_en = data[0];
                csaf_pkg::CFG_MAC_FILTER_ON:  mac_filter = data[0];
                csaf_pkg::CFG_FILTER_ADDRESS: match_addr = data[MAC_W-1:0];
                csaf_pkg::CFG_MIN_SIGNAL:     min_rssi = data[RSSI_W-1:0];
                csaf_pkg::CFG_LIMIT_HZ: begin
                    rate_hz      = data[RATE_W-1:0];
                    last_pass_ms = '0;
                end
                default: ;
            endcase
        endfunction

        // The checks in priority order. A rate pass moves the last-pass
        // time even when the sample is then dropped for a full queue.
        function csaf_pkg::t_verdict screen_sample(t_sample s);
            logic [TIME_W-1:0] period;
            logic [TIME_W-1:0] elapsed;
            if (!run_en)
                return csaf_pkg::V_IDLE;
            if (s.csi_len == '0 || s.csi_len > csaf_pkg::MAX_SAMPLE_BYTES) begin
                totals.bad_length++;
                return csaf_pkg::V_BADLEN;
            end
            if (mac_filter && s.src_mac != match_addr)
                return csaf_pkg::V_MAC;
            if (s.rssi < min_rssi) begin
                totals.weak_signal++;
                return csaf_pkg::V_WEAK;
            end
            if (rate_hz != '0) begin
                period  = TIME_W'(MS_PER_SEC) / TIME_W'(rate_hz);
                elapsed = s.now_ms - last_pass_ms;
                if (elapsed < period) begin
                    totals.rate_limited++;
                    return csaf_pkg::V_RATE;
                end
                last_pass_ms = s.now_ms;
            end
            if (s.queue_full) begin
                totals.dropped++;
                return csaf_pkg::V_DROPPED;
            end
            totals.accepted++;
            return csaf_pkg::V_ACCEPTED;
        endfunction

        function void note_sample(t_sample s);
            csaf_pkg::t_verdict v;
            t_tally             snap;
            v            = screen_sample(s);
            snap         = totals;
            snap.verdict = v;
            due_verdicts.push_back(snap);
        endfunction

        function void check_verdict(t_tally got);
            t_tally want;
            if (due_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result word with none expected, verdict %0d",
                             $realtime, got.verdict);
                return;
            end
            want = due_verdicts.pop_front();
            if (got.verdict !== want.verdict || got.accepted !== want.accepted ||
                got.bad_length !== want.bad_length ||
                got.weak_signal !== want.weak_signal ||
                got.rate_limited !== want.rate_limited || got.dropped !== want.dropped) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: expected verdict %0d acc %0d bad %0d weak %0d rate %0d drop %0d",
                             $realtime, want.verdict, want.accepted, want.bad_length,
                             want.weak_signal, want.rate_limited, want.dropped);
                    $display("%0t: actual   verdict %0d acc %0d bad %0d weak %0d rate %0d drop %0d",
                             $realtime, got.verdict, got.accepted, got.bad_length,
                             got.weak_signal, got.rate_limited, got.dropped);
                end
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [TIME_W-1:0]        i_now_ms = '0;
    logic [MAC_W-1:0]         i_src_mac = '0;
    logic signed [RSSI_W-1:0] i_rssi = '0;
    logic [LEN_W-1:0]         i_csi_len = '0;
    logic                     i_queue_full = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [2:0]               o_verdict;
    logic [COUNT_W-1:0]       o_accepted_total;
    logic [COUNT_W-1:0]       o_bad_length_total;
    logic [COUNT_W-1:0]       o_weak_signal_total;
    logic [COUNT_W-1:0]       o_rate_limited_total;
    logic [COUNT_W-1:0]       o_dropped_total;

    admission_scoreboard sb = new();

    // Idling switches for each side, and whether valid is currently raised.
    bit                in_idling = 1'b1;
    bit                out_idling = 1'b1;
    bit                in_armed = 1'b0;
    logic [TIME_W-1:0] clock_ms;
    t_tally            seen;

    csi_sample_admission_filter_top u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_now_ms             (i_now_ms),
        .i_src_mac            (i_src_mac),
        .i_rssi               (i_rssi),
        .i_csi_len            (i_csi_len),
        .i_queue_full         (i_queue_full),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_verdict            (o_verdict),
        .o_accepted_total     (o_accepted_total),
        .o_bad_length_total   (o_bad_length_total),
        .o_weak_signal_total  (o_weak_signal_total),
        .o_rate_limited_total (o_rate_limited_total),
        .o_dropped_total      (o_dropped_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side. The outputs are read right at the edge, so they hold the
    // values the block presented before it. The stall for the next edge is
    // chosen in the same step.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.verdict      = csaf_pkg::t_verdict'(o_verdict);
            seen.accepted     = o_accepted_total;
            seen.bad_length   = o_bad_length_total;
            seen.weak_signal  = o_weak_signal_total;
            seen.rate_limited = o_rate_limited_total;
            seen.dropped      = o_dropped_total;
            sb.check_verdict(seen);
        end
        i_out_stall <= out_idling && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Lowers valid once. A word that follows straight away keeps valid high,
    // so valid never gets two updates in one step.
    task automatic drop_valid();
        if (in_armed) begin
            i_in_valid <= 1'b0;
            in_armed = 1'b0;
        end
    endtask

    // Presents one sample word after a random gap, holds it until it is
    // taken, and then notes it in the scoreboard.
    task automatic send_word(logic [TIME_W-1:0] now, logic [MAC_W-1:0] mac,
                             logic signed [RSSI_W-1:0] rssi, logic [LEN_W-1:0] len,
                             logic full);
        t_sample s;
        s.now_ms     = now;
        s.src_mac    = mac;
        s.rssi       = rssi;
        s.csi_len    = len;
        s.queue_full = full;
        while (in_idling && $urandom_range(0, 99) < IDLE_PCT) begin
            drop_valid();
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_now_ms     <= now;
        i_src_mac    <= mac;
        i_rssi       <= rssi;
        i_csi_len    <= len;
        i_queue_full <= full;
        in_armed = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
    endtask

    // Stops sending and waits until every expected result word has come
    // back. Each word yields exactly one result, so the block is idle then.
    task automatic drain();
        drop_valid();
        while (sb.due_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Half of the time the unused upper data bits carry random junk, which
    // the register must ignore.
    function automatic logic [CFG_DATA_W-1:0] cfg_word(int unsigned w,
                                                       logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
        if ($urandom_range(0, 1) != 0)
            return (v & keep) | (CFG_DATA_W'({$urandom, $urandom}) & ~keep);
        return v & keep;
    endfunction

    // A fresh setting of all five registers, leaning on the extremes, plus
    // a write to an index that does not exist.
    task automatic shuffle_config(bit run);
        logic [MAC_W-1:0]         addr;
        logic signed [RSSI_W-1:0] floor_dbm;
        logic [RATE_W-1:0]        hz;
        case ($urandom_range(0, 3))
            0:       addr = '0;
            1:       addr = '1;
            default: addr = MAC_W'({$urandom, $urandom});
        endcase
        case ($urandom_range(0, 5))
            0:       floor_dbm = csaf_pkg::MIN_SIGNAL_RESET;
            1:       floor_dbm = 8'h80;
            2:       floor_dbm = '0;
            3:       floor_dbm = 8'sd127;
            default: floor_dbm = RSSI_W'(-int'($urandom_range(0, 127)));
        endcase
        case ($urandom_range(0, 5))
            0:       hz = '0;
            1:       hz = RATE_W'(1);
            2:       hz = RATE_W'(MS_PER_SEC);
            3:       hz = RATE_W'($urandom_range(MS_PER_SEC + 1, (1 << RATE_W) - 1));
            default: hz = RATE_W'($urandom_range(1, MS_PER_SEC));
        endcase
        set_register(csaf_pkg::CFG_ENABLE_RUN, cfg_word(1, CFG_DATA_W'(run)));
        set_register(csaf_pkg::CFG_MAC_FILTER_ON,
                     cfg_word(1, CFG_DATA_W'($urandom_range(0, 1))));
        set_register(csaf_pkg::CFG_FILTER_ADDRESS, addr);
        set_register(csaf_pkg::CFG_MIN_SIGNAL, cfg_word(RSSI_W, CFG_DATA_W'(floor_dbm)));
        set_register(csaf_pkg::CFG_LIMIT_HZ, cfg_word(RATE_W, CFG_DATA_W'(hz)));
        set_register(CFG_IDX_W'($urandom_range(csaf_pkg::CFG_LIMIT_HZ + 1,
                                               (1 << CFG_IDX_W) - 1)),
                     CFG_DATA_W'({$urandom, $urandom}));
    endtask

    // Mostly well-formed samples that get through the early checks, so the
    // rate limit and the queue are exercised often. The time advances by
    // steps around the rate periods, with the odd jump and wrap.
    task automatic send_random();
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
        logic [LEN_W-1:0]         len;
        int unsigned              pick;
        int                       lo;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            clock_ms += $urandom_range(0, 1100);
        else if (pick < 85)
            clock_ms += $urandom_range(0, 3);
        else if (pick < 95)
            clock_ms += $urandom;
        else
            clock_ms = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            len = LEN_W'($urandom_range(1, csaf_pkg::MAX_SAMPLE_BYTES));
        else if (pick < 88)
            len = '0;
        else
            len = LEN_W'($urandom_range(csaf_pkg::MAX_SAMPLE_BYTES + 1, (1 << LEN_W) - 1));
        pick = $urandom_range(0, 99);
        if (sb.mac_filter && pick < 80)
            mac = sb.match_addr;
        else if (pick < 90)
            mac = sb.match_addr ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
        else
            mac = MAC_W'({$urandom, $urandom});
        lo = sb.min_rssi;
        if ($urandom_range(0, 99) < 75)
            rssi = RSSI_W'(int'($urandom_range(lo + 128, 255)) - 128);
        else
            rssi = RSSI_W'($urandom);
        send_word(clock_ms, mac, rssi, len, $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned count;
        sent     = 0;
        phase    = 0;
        clock_ms = $urandom;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the filter is not running: samples come back idle.
        send_word('0, '0, '0, 16'd10, 1'b0);
        send_word('1, '1, 8'sd127, '1, 1'b1);
        set_register(csaf_pkg::CFG_ENABLE_RUN, CFG_DATA_W'(1));

        // Field extremes and the length band, then the order of the checks.
        send_word('0, '0, '0, 16'd1, 1'b0);
        send_word('1, '1, 8'sd127, csaf_pkg::MAX_SAMPLE_BYTES, 1'b0);
        send_word('0, '0, '0, '0, 1'b0);
        send_word('0, '0, '0, csaf_pkg::MAX_SAMPLE_BYTES + 16'd1, 1'b0);
        send_word('0, '0, '0, '1, 1'b0);
        send_word('0, '0, 8'h80, 16'd20, 1'b0);
        send_word('0, '0, -8'sd127, 16'd20, 1'b0);
        send_word('0, '0, '0, 16'd20, 1'b1);
        send_word('0, '0, 8'h80, '0, 1'b0);

        // Address filter: a mismatch outranks a weak signal and counts
        // nothing, but a bad length still wins over it.
        set_register(csaf_pkg::CFG_FILTER_ADDRESS, 48'h0123_4567_89AB);
        set_register(csaf_pkg::CFG_MAC_FILTER_ON, CFG_DATA_W'(1));
        send_word('0, 48'h0123_4567_89AB, '0, 16'd64, 1'b0);
        send_word('0, 48'h0123_4567_89AA, '0, 16'd64, 1'b0);
        send_word('0, 48'h0123_4567_89AA, 8'h80, 16'd64, 1'b0);
        send_word('0, 48'h0123_4567_89AA, '0, '0, 1'b0);

        // Signal minimum beyond its usual range, at both ends.
        set_register(csaf_pkg::CFG_MIN_SIGNAL, 48'd127);
        send_word('0, 48'h0123_4567_89AB, 8'sd127, 16'd64, 1'b0);
        send_word('0, 48'h0123_4567_89AB, 8'sd126, 16'd64, 1'b0);
        set_register(csaf_pkg::CFG_MIN_SIGNAL, 48'h80);
        send_word('0, 48'h0123_4567_89AB, 8'h80, 16'd64, 1'b0);
        set_register(csaf_pkg::CFG_MAC_FILTER_ON, CFG_DATA_W'(0));

        // One hertz: a 1000 ms period, measured across the time wrap. A pass
        // that is dropped for a full queue still moves the last-pass time.
        set_register(csaf_pkg::CFG_LIMIT_HZ, CFG_DATA_W'(1));
        send_word(32'd500, '0, '0, 16'd8, 1'b0);
        send_word(32'd1000, '0, '0, 16'd8, 1'b0);
        send_word(32'd1999, '0, '0, 16'd8, 1'b0);
        send_word('1, '0, '0, 16'd8, 1'b1);
        send_word(32'd998, '0, '0, 16'd8, 1'b0);
        send_word(32'd999, '0, '0, 16'd8, 1'b0);

        // Fastest legal rate, then a rate above range whose period is zero.
        set_register(csaf_pkg::CFG_LIMIT_HZ, CFG_DATA_W'(MS_PER_SEC));
        send_word(32'd5, '0, '0, 16'd8, 1'b0);
        send_word(32'd5, '0, '0, 16'd8, 1'b0);
        set_register(csaf_pkg::CFG_LIMIT_HZ, CFG_DATA_W'(1023));
        send_word(32'd5, '0, '0, 16'd8, 1'b0);
        send_word(32'd5, '0, '0, 16'd8, 1'b0);
        set_register(CFG_IDX_W'(csaf_pkg::CFG_LIMIT_HZ + 1), '1);
        send_word(32'd5, '0, '0, 16'd8, 1'b0);

        // Random phases, each under a fresh setting. Phase one stops the
        // filter for a few words; phase three runs with no idling on either
        // side; phase five pauses the sender mid-way until all is drained.
        while (sent < RANDOM_WORDS) begin
            shuffle_config(phase != 1);
            in_idling  = (phase != 3);
            out_idling = (phase != 3);
            count = (phase == 1) ? 6 : $urandom_range(30, 70);
            for (int k = 0; k < count; k++) begin
                send_random();
                if (phase != 1)
                    sent++;
                if (phase == 5 && k == count / 2)
                    drain();
            end
            phase++;
        end
        in_idling  = 1'b1;
        out_idling = 1'b1;

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("csi_sample_admission_filter_top: match");
        else
            $display("csi_sample_admission_filter_top: mismatch");
        $finish;
    end

    // Far beyond the slowest correct run, even with long stalls on both sides.
    initial begin
        #5_000_000;
        $display("csi_sample_admission_filter_top: mismatch");
        $finish;
    end

endmodule
